// ----- src/tccw_pkg.sv -----
`timescale 1ns / 1ps
// Package for the text console character writer: transfer structs, codes,
// controller states and the command/status structs. Depends on nothing.

package tccw_pkg;

    // Default screen geometry and tab spacing.
    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_CELLS_DEF = 4;

    // Attribute byte after reset.
    localparam logic [7:0] COLOR_RESET = 8'd7;

    // Control characters.
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_VTAB = 8'h0B;
    localparam logic [7:0] CH_CR   = 8'h0D;

    typedef struct packed {
        logic        mode;
        logic [7:0]  character;
        logic [10:0] read_index;
    } item_t;

    typedef struct packed {
        logic [10:0] cursor_cell;
        logic        scrolled;
        logic [7:0]  cell_character;
        logic [7:0]  cell_color;
    } result_t;

    typedef enum logic [2:0] {
        MV_NONE,
        MV_INC,
        MV_DEC,
        MV_LF,
        MV_VT,
        MV_CR,
        MV_LAST_ROW
    } move_t;

    typedef enum logic [2:0] {
        K_READ,
        K_TAB,
        K_VT,
        K_CR,
        K_LF,
        K_BS,
        K_PRINT
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_TAB,
        ST_COPY,
        ST_WIPE,
        ST_PUT
    } state_t;

    typedef struct packed {
        move_t move;
        logic  load_item;
        logic  rd_cell;
        logic  rd_copy;
        logic  wr_zero;
        logic  wr_char;
        logic  use_held;
        logic  idx_clr;
        logic  idx_inc;
        logic  emit;
        logic  emit_read;
        logic  scrolled;
    } ctl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  at_end;
        logic  tab_stop;
        logic  idx_copy_end;
        logic  idx_last;
    } dp_status_t;

endpackage

// ----- src/tccw_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/tccw_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the console writer.
// Depends on tccw_pkg; drives the datapath through ctl_cmd_t.

module tccw_ctrl import tccw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output logic       busy,
    output ctl_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.move   = MV_NONE;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_zero = 1'b1;
                cmd.idx_inc = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    case (status.kind)
                        K_READ:
                        begin
                            cmd.rd_cell = 1'b1;
                            state_next  = ST_READ;
                        end
                        K_TAB:
                        begin
                            if (status.at_end)
                            begin
                                cmd.emit = 1'b1;
                            end
                            else
                            begin
                                cmd.move   = MV_INC;
                                state_next = ST_TAB;
                            end
                        end
                        K_VT:
                        begin
                            cmd.move = MV_VT;
                            cmd.emit = 1'b1;
                        end
                        K_LF:
                        begin
                            cmd.move = MV_LF;
                            cmd.emit = 1'b1;
                        end
                        K_CR:
                        begin
                            cmd.move = MV_CR;
                            cmd.emit = 1'b1;
                        end
                        K_BS:
                        begin
                            cmd.move = MV_DEC;
                            cmd.emit = 1'b1;
                        end
                        default:
                        begin
                            if (status.at_end)
                            begin
                                cmd.idx_clr = 1'b1;
                                state_next  = ST_COPY;
                            end
                            else
                            begin
                                cmd.wr_char = 1'b1;
                                cmd.move    = MV_INC;
                                cmd.emit    = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_read = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_TAB:
            begin
                if (status.tab_stop || status.at_end)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.move = MV_INC;
                end
            end
            ST_COPY:
            begin
                // The last copy write drains here while no new read is issued.
                if (status.idx_copy_end)
                begin
                    state_next = ST_WIPE;
                end
                else
                begin
                    cmd.rd_copy = 1'b1;
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_WIPE:
            begin
                cmd.wr_zero = 1'b1;
                cmd.idx_inc = 1'b1;
                if (status.idx_last)
                begin
                    cmd.move   = MV_LAST_ROW;
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                cmd.wr_char  = 1'b1;
                cmd.use_held = 1'b1;
                cmd.move     = MV_INC;
                cmd.emit     = 1'b1;
                cmd.scrolled = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- src/tccw_dpath.sv -----
`timescale 1ns / 1ps
// Datapath of the console writer: cursor counters, screen RAM, result register.
// Depends on tccw_pkg and tccw_ram; commanded by tccw_ctrl.

module tccw_dpath import tccw_pkg::*; #(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TAB_CELLS = TAB_CELLS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    input  ctl_cmd_t   cmd,
    output dp_status_t status,
    output result_t    result,
    output logic       done
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int CUR_W    = $clog2(CELLS + 1);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int ROW_W    = $clog2(ROWS + 1);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int PH_W     = $clog2(TAB_CELLS + 1);
    localparam int RS_W     = ROW_W + 3;
    localparam int PH_LF    = COLUMNS % TAB_CELLS;
    localparam int PH_VT    = (4 * COLUMNS) % TAB_CELLS;
    localparam int PH_END   = CELLS % TAB_CELLS;
    localparam int PH_LAST  = ((ROWS - 1) * COLUMNS) % TAB_CELLS;
    localparam int COPY_END = CELLS - COLUMNS;

    // Phase arithmetic modulo the tab spacing; the addend is below TAB_CELLS.
    function automatic logic [PH_W-1:0] add_ph(input logic [PH_W-1:0] a, input int c);
        logic [PH_W:0] s;
        s = {1'b0, a} + (PH_W + 1)'(c);
        if (s >= (PH_W + 1)'(TAB_CELLS))
        begin
            s = s - (PH_W + 1)'(TAB_CELLS);
        end
        return s[PH_W-1:0];
    endfunction

    function automatic logic [PH_W-1:0] sub_ph(input logic [PH_W-1:0] a, input int c);
        logic [PH_W:0] s;
        s = {1'b0, a} + (PH_W + 1)'(TAB_CELLS) - (PH_W + 1)'(c);
        if (s >= (PH_W + 1)'(TAB_CELLS))
        begin
            s = s - (PH_W + 1)'(TAB_CELLS);
        end
        return s[PH_W-1:0];
    endfunction

    // Cursor held both as a linear cell index and as row, column and tab phase.
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PH_W-1:0]   ph_reg, ph_next;
    logic [PH_W-1:0]   rph_reg, rph_next;
    logic [RS_W-1:0]   row_sum;

    logic [CUR_W-1:0]  idx_reg;
    logic              pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [7:0]        color_reg;
    logic [7:0]        char_reg;
    logic              in_range_reg;
    logic              done_reg;
    result_t           result_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    always_comb
    begin
        cursor_next = cursor_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        ph_next     = ph_reg;
        rph_next    = rph_reg;
        row_sum     = {3'b000, row_reg} + ((cmd.move == MV_VT) ? RS_W'(4) : RS_W'(1));
        case (cmd.move)
            MV_INC:
            begin
                cursor_next = cursor_reg + 1'b1;
                ph_next     = add_ph(ph_reg, 1 % TAB_CELLS);
                if (col_reg == COL_W'(COLUMNS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    rph_next = add_ph(rph_reg, PH_LF);
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            MV_DEC:
            begin
                if (cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - 1'b1;
                    ph_next     = sub_ph(ph_reg, 1 % TAB_CELLS);
                    if (col_reg == '0)
                    begin
                        col_next = COL_W'(COLUMNS - 1);
                        row_next = row_reg - 1'b1;
                        rph_next = sub_ph(rph_reg, PH_LF);
                    end
                    else
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
            end
            MV_LF, MV_VT:
            begin
                if ((row_sum > RS_W'(ROWS)) || ((row_sum == RS_W'(ROWS)) && (col_reg != '0)))
                begin
                    // Saturate at the cell just past the end of the screen.
                    cursor_next = CUR_W'(CELLS);
                    row_next    = ROW_W'(ROWS);
                    col_next    = '0;
                    ph_next     = PH_W'(PH_END);
                    rph_next    = PH_W'(PH_END);
                end
                else if (cmd.move == MV_VT)
                begin
                    cursor_next = cursor_reg + CUR_W'(4 * COLUMNS);
                    row_next    = row_sum[ROW_W-1:0];
                    ph_next     = add_ph(ph_reg, PH_VT);
                    rph_next    = add_ph(rph_reg, PH_VT);
                end
                else
                begin
                    cursor_next = cursor_reg + CUR_W'(COLUMNS);
                    row_next    = row_sum[ROW_W-1:0];
                    ph_next     = add_ph(ph_reg, PH_LF);
                    rph_next    = add_ph(rph_reg, PH_LF);
                end
            end
            MV_CR:
            begin
                cursor_next = cursor_reg - CUR_W'(col_reg);
                col_next    = '0;
                ph_next     = rph_reg;
            end
            MV_LAST_ROW:
            begin
                cursor_next = CUR_W'(COPY_END);
                row_next    = ROW_W'(ROWS - 1);
                col_next    = '0;
                ph_next     = PH_W'(PH_LAST);
                rph_next    = PH_W'(PH_LAST);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            ph_reg     <= '0;
            rph_reg    <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            color_reg  <= COLOR_RESET;
        end
        else
        begin
            cursor_reg <= cursor_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            ph_reg     <= ph_next;
            rph_reg    <= rph_next;
            pend_reg   <= cmd.rd_copy;
            done_reg   <= cmd.emit;
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cfg_we)
            begin
                color_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= ADDR_W'(idx_reg);
        if (cmd.load_item)
        begin
            char_reg     <= item.character;
            in_range_reg <= (32'(item.read_index) < CELLS);
        end
        if (cmd.emit)
        begin
            result_reg.cursor_cell    <= 11'(cursor_next);
            result_reg.scrolled       <= cmd.scrolled;
            result_reg.cell_character <= (cmd.emit_read && in_range_reg) ? ram_rdata[7:0] : 8'd0;
            result_reg.cell_color     <= (cmd.emit_read && in_range_reg) ? ram_rdata[15:8] : 8'd0;
        end
    end

    // A pending copy write has the port; the controller never overlaps it.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(idx_reg);
        ram_wdata = '0;
        if (pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.wr_zero)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.wr_char)
        begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(cursor_reg);
            ram_wdata = {color_reg, cmd.use_held ? char_reg : item.character};
        end
        ram_raddr = cmd.rd_cell ? ADDR_W'(item.read_index)
                                : ADDR_W'(idx_reg + CUR_W'(COLUMNS));
    end

    tccw_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_screen (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        status.kind = K_PRINT;
        if (item.mode)
        begin
            status.kind = K_READ;
        end
        else
        begin
            case (item.character)
                CH_TAB:  status.kind = K_TAB;
                CH_VTAB: status.kind = K_VT;
                CH_CR:   status.kind = K_CR;
                CH_LF:   status.kind = K_LF;
                CH_BS:   status.kind = K_BS;
                default: status.kind = K_PRINT;
            endcase
        end
        status.at_end       = (row_reg == ROW_W'(ROWS));
        status.tab_stop     = (ph_reg == '0);
        status.idx_copy_end = (idx_reg == CUR_W'(COPY_END));
        status.idx_last     = (idx_reg == CUR_W'(CELLS - 1));
    end

    assign result = result_reg;
    assign done   = done_reg;

    a_copy_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !(cmd.wr_zero || cmd.wr_char))
        else $error("copy write collides with another RAM write");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CUR_W'(CELLS))
        else $error("cursor beyond the end of the screen");

    a_row_view: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg == ROW_W'(ROWS)) == (cursor_reg == CUR_W'(CELLS)))
        else $error("row counter disagrees with linear cursor");

    a_write_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_char |-> (cursor_reg < CUR_W'(CELLS)))
        else $error("character write past the end of the screen");

endmodule

// ----- src/text_console_character_writer.sv -----
`timescale 1ns / 1ps
// Top level of the text console character writer.
// Depends on tccw_pkg, tccw_ctrl, tccw_dpath and tccw_ram.
//
//   Channel   Signals                      Transfer when
//   item      start, busy, item            start high and busy low
//   result    done, result                 done high (one cycle, no stall)
//   config    cfg_valid, cfg_ready, data   cfg_valid and cfg_ready high
//
// After reset the block is busy while it clears the screen RAM one cell per
// cycle; configuration writes are taken during that time. For cursor moves and
// characters written before the end, the result appears in the next cycle and a
// new item can be accepted then. A read returns its cell through the registered
// RAM read and the READ state. A tab steps the cursor one cell per cycle until a
// tab stop or the end. A character written at the end scrolls through the single
// RAM write port: after the cycle that takes it, COPY moves the rows up, WIPE
// clears the last row and PUT writes the character. The receiver cannot stall;
// each result shows for one cycle.

module text_console_character_writer import tccw_pkg::*; #(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TAB_CELLS = TAB_CELLS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  item_t      item,
    output logic       done,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    // The color register can be written at any time; the contract only
    // writes it while no item is in flight.
    assign cfg_ready = 1'b1;

    // The controller sequences each item; the datapath holds the cursor,
    // the screen RAM and the result register.
    tccw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .busy  (busy),
        .cmd   (cmd)
    );

    tccw_dpath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_CELLS(TAB_CELLS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_data(cfg_data),
        .cmd     (cmd),
        .status  (status),
        .result  (result),
        .done    (done)
    );

endmodule
